/* rtl/dsc_pkg.sv */
// ----------------------------------------------------------------------------
// dsc_pkg
// Types and constants shared by the distinct subsequence counter and its cells.
// ----------------------------------------------------------------------------
package dsc_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int COUNT_W         = 32;
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int CHARS_PER_WORD  = CFG_DATA_W / CHAR_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH     = 2'd0,
        REG_PATTERN_CHARS_LOW  = 2'd1,
        REG_PATTERN_CHARS_HIGH = 2'd2
    } cfg_reg_t;

    // input actions
    typedef enum logic {
        ACT_RESTART = 1'b0,
        ACT_CHAR    = 1'b1
    } action_t;

    typedef struct packed {
        logic              action;
        logic [CHAR_W-1:0] text_char;
    } in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               saturated;
    } out_t;

    // control broadcast to every cell
    typedef struct packed {
        logic              clear;
        logic              step;
        logic [CHAR_W-1:0] text_char;
    } cell_ctrl_t;

endpackage

/* rtl/distinct_subsequence_counter.sv */
// ----------------------------------------------------------------------------
// distinct_subsequence_counter
// Counts distinct subsequences of a streamed text that equal a configured
// pattern, with one saturating count cell per pattern prefix.
// ----------------------------------------------------------------------------
// A beat is taken in every cycle in which the result register is empty or
// being drained: a text character updates each matching active prefix cell in
// the same clock, from its own count and its left neighbor's, and the count
// for the whole pattern appears on the result channel in the cycle after the
// input beat. The single result register sets the pace, so the block sustains
// one item per cycle while the result side keeps up. A restart beat clears
// every cell and the saturation flag. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module distinct_subsequence_counter #(
    parameter int MAX_PATTERN = dsc_pkg::MAX_PATTERN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  dsc_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output dsc_pkg::out_t                   m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dsc_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [dsc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [dsc_pkg::LEN_W-1:0]        pattern_length_reg;
    logic [2*dsc_pkg::CFG_DATA_W-1:0] pattern_chars_reg;
    logic [dsc_pkg::LEN_W-1:0]        act_len;

    logic                             out_valid_reg;
    dsc_pkg::out_t                    out_data_reg;
    logic                             sat_reg;
    logic                             sat_next;

    logic                             accept;
    dsc_pkg::cell_ctrl_t              ctrl;
    logic [dsc_pkg::COUNT_W-1:0]      counts      [MAX_PATTERN];
    logic [dsc_pkg::COUNT_W-1:0]      counts_next [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]           hits;
    logic [dsc_pkg::COUNT_W-1:0]      full_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
            pattern_chars_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                dsc_pkg::REG_PATTERN_LENGTH: begin
                    pattern_length_reg <= cfg_wdata[dsc_pkg::LEN_W-1:0];
                end
                dsc_pkg::REG_PATTERN_CHARS_LOW: begin
                    pattern_chars_reg[dsc_pkg::CFG_DATA_W-1:0] <= cfg_wdata;
                end
                dsc_pkg::REG_PATTERN_CHARS_HIGH: begin
                    pattern_chars_reg[2*dsc_pkg::CFG_DATA_W-1:dsc_pkg::CFG_DATA_W]
                        <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign act_len = (pattern_length_reg > dsc_pkg::LEN_W'(MAX_PATTERN))
                   ? dsc_pkg::LEN_W'(MAX_PATTERN) : pattern_length_reg;

    // input beat control
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign ctrl.clear     = accept && (s_data.action == dsc_pkg::ACT_RESTART);
    assign ctrl.step      = accept && (s_data.action == dsc_pkg::ACT_CHAR);
    assign ctrl.text_char = s_data.text_char;

    // cell chain
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic [dsc_pkg::COUNT_W-1:0] shorter;
        if (j == 0) begin : g_first
            assign shorter = dsc_pkg::COUNT_W'(1);
        end else begin : g_rest
            assign shorter = counts[j-1];
        end

        dsc_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (ctrl),
            .active        (dsc_pkg::LEN_W'(j) < act_len),
            .pattern_char  (pattern_chars_reg[dsc_pkg::CHAR_W*j +: dsc_pkg::CHAR_W]),
            .shorter_count (shorter),
            .count         (counts[j]),
            .count_next    (counts_next[j]),
            .sat_hit       (hits[j])
        );
    end

    // full pattern count after this beat
    always_comb begin
        full_next = dsc_pkg::COUNT_W'(1);
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (act_len == dsc_pkg::LEN_W'(j + 1)) begin
                full_next = counts_next[j];
            end
        end
    end

    assign sat_next = ctrl.clear ? 1'b0 : (sat_reg || (|hits));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg <= 1'b0;
        end else begin
            sat_reg <= sat_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg.match_count <= full_next;
            out_data_reg.saturated   <= sat_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* rtl/dsc_cell.sv */
// ----------------------------------------------------------------------------
// dsc_cell
// One prefix count: adds the shorter prefix count on a matching character,
// saturating, and hands its count on to the next cell.
// ----------------------------------------------------------------------------
module dsc_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dsc_pkg::cell_ctrl_t          ctrl,
    input  logic                         active,
    input  logic [dsc_pkg::CHAR_W-1:0]   pattern_char,
    input  logic [dsc_pkg::COUNT_W-1:0]  shorter_count,
    output logic [dsc_pkg::COUNT_W-1:0]  count,
    output logic [dsc_pkg::COUNT_W-1:0]  count_next,
    output logic                         sat_hit
);

    logic [dsc_pkg::COUNT_W-1:0] count_reg;
    logic [dsc_pkg::COUNT_W:0]   sum;
    logic                        upd;

    assign sum = {1'b0, count_reg} + {1'b0, shorter_count};
    assign upd = ctrl.step && active && (pattern_char == ctrl.text_char);

    always_comb begin
        count_next = count_reg;
        sat_hit    = 1'b0;
        if (ctrl.clear) begin
            count_next = '0;
        end else if (upd) begin
            if (sum[dsc_pkg::COUNT_W]) begin
                count_next = dsc_pkg::COUNT_MAX;
                sat_hit    = 1'b1;
            end else begin
                count_next = sum[dsc_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

/* tb/tb_distinct_subsequence_counter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_distinct_subsequence_counter
// Streams restart and text beats into the counter under a series of pattern
// settings and checks every result beat against a cycle-free prediction of
// the per-prefix counts. Covers the empty and clamped pattern lengths,
// inactive prefixes, mid-text pattern changes, and saturating runs.
// Random idling on both channels, one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_distinct_subsequence_counter;

    localparam int MAX_PAT     = dsc_pkg::MAX_PATTERN_DEF;
    localparam int CW          = dsc_pkg::CHAR_W;
    localparam int NW          = dsc_pkg::COUNT_W;
    localparam int DW          = dsc_pkg::CFG_DATA_W;
    localparam int CPW         = dsc_pkg::CHARS_PER_WORD;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_BEATS = 104;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam logic [dsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    dsc_pkg::in_t                  s_data    = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    dsc_pkg::out_t                 m_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [dsc_pkg::CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [DW-1:0]                 cfg_wdata = '0;

    dsc_pkg::in_t  text_beats[$];
    dsc_pkg::out_t expected_totals[$];

    // predicted block state
    logic [NW-1:0]                 prefix_cnt [MAX_PAT];
    logic                          sat_flag;
    logic [dsc_pkg::LEN_W-1:0]     pat_len;
    logic [DW-1:0]                 pat_lo;
    logic [DW-1:0]                 pat_hi;

    logic in_fire      = 1'b0;
    int   send_gap     = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    int   idle_level   = 0;
    bit   hold_request = 1'b0;
    bit   hold_done    = 1'b0;

    int errors          = 0;
    int beats_queued    = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int saturated_seen  = 0;

    distinct_subsequence_counter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic dsc_pkg::out_t advance_prefix_counts(dsc_pkg::in_t beat);
        logic [NW-1:0]  prev [MAX_PAT];
        logic [NW:0]    sum;
        logic [NW:0]    shorter;
        logic [CW-1:0]  pchar;
        int             len;
        int             j;
        dsc_pkg::out_t  total;
        len = (int'(pat_len) > MAX_PAT) ? MAX_PAT : int'(pat_len);
        if (beat.action == dsc_pkg::ACT_RESTART) begin
            for (j = 0; j < MAX_PAT; j++) prefix_cnt[j] = '0;
            sat_flag = 1'b0;
        end else begin
            prev = prefix_cnt;
            for (j = 0; j < len; j++) begin
                if (j < CPW) begin
                    pchar = pat_lo[CW*j +: CW];
                end else begin
                    pchar = pat_hi[CW*(j-CPW) +: CW];
                end
                if (pchar == beat.text_char) begin
                    if (j == 0) begin
                        shorter = (NW+1)'(1);
                    end else begin
                        shorter = {1'b0, prev[j-1]};
                    end
                    sum = {1'b0, prev[j]} + shorter;
                    if (sum > {1'b0, dsc_pkg::COUNT_MAX}) begin
                        sum = {1'b0, dsc_pkg::COUNT_MAX};
                        sat_flag = 1'b1;
                    end
                    prefix_cnt[j] = sum[NW-1:0];
                end
            end
        end
        if (len == 0) begin
            total.match_count = NW'(1);
        end else begin
            total.match_count = prefix_cnt[len-1];
        end
        total.saturated = sat_flag;
        return total;
    endfunction

    // prediction and result checking
    always @(posedge aclk) begin
        dsc_pkg::out_t want;
        in_fire <= aresetn && s_valid && s_ready;
        if (!aresetn) begin
            foreach (prefix_cnt[j]) prefix_cnt[j] = '0;
            sat_flag = 1'b0;
            pat_len  = '0;
            pat_lo   = '0;
            pat_hi   = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_totals.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: result beat with none expected: count %0d sat %0b",
                                 $time, m_data.match_count, m_data.saturated);
                    end
                end else begin
                    want = expected_totals.pop_front();
                    results_checked++;
                    if (m_data.saturated === 1'b1) saturated_seen++;
                    if (m_data.match_count !== want.match_count ||
                        m_data.saturated !== want.saturated) begin
                        errors++;
                        if (errors <= 10) begin
                            $display({"%0t: result %0d expected count %0d sat %0b, ",
                                      "got count %0d sat %0b"},
                                     $time, results_checked, want.match_count,
                                     want.saturated, m_data.match_count,
                                     m_data.saturated);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    dsc_pkg::REG_PATTERN_LENGTH:
                        pat_len = cfg_wdata[dsc_pkg::LEN_W-1:0];
                    dsc_pkg::REG_PATTERN_CHARS_LOW:  pat_lo = cfg_wdata;
                    dsc_pkg::REG_PATTERN_CHARS_HIGH: pat_hi = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_totals.push_back(advance_prefix_counts(s_data));
            end
        end
    end

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (text_beats.size() != 0 && $urandom_range(0, 15) < idle_level) begin
                send_gap = $urandom_range(0, 10);
                s_valid <= 1'b0;
            end else if (text_beats.size() != 0) begin
                s_data  <= text_beats.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off
    always @(negedge aclk) begin
        if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 15) < idle_level) begin
            stall_left = $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic push_restart();
        dsc_pkg::in_t beat;
        beat.action    = dsc_pkg::ACT_RESTART;
        beat.text_char = CW'($urandom);
        text_beats.push_back(beat);
        beats_queued++;
    endtask

    task automatic push_char(input logic [CW-1:0] ch);
        dsc_pkg::in_t beat;
        beat.action    = dsc_pkg::ACT_CHAR;
        beat.text_char = ch;
        text_beats.push_back(beat);
        beats_queued++;
    endtask

    task automatic write_reg(input logic [dsc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [DW-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic write_pattern(input int len, input logic [DW-1:0] lo,
                                 input logic [DW-1:0] hi);
        write_reg(dsc_pkg::REG_PATTERN_LENGTH, DW'(len));
        write_reg(dsc_pkg::REG_PATTERN_CHARS_LOW, lo);
        write_reg(dsc_pkg::REG_PATTERN_CHARS_HIGH, hi);
    endtask

    task automatic wait_idle();
        while (text_beats.size() != 0 || s_valid || expected_totals.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2) @(posedge aclk);
    endtask

    initial begin
        logic [CW-1:0] alphabet [4];
        logic [CW-1:0] pat_chars [MAX_PAT];
        logic [DW-1:0] lo;
        logic [DW-1:0] hi;
        int            p;
        int            k;
        int            len;
        int            eff;
        int            nsym;
        int            run;
        int            stop;
        int            r;
        bit            sat_mode;
        bit            restart_first;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty pattern after reset
        idle_level = 2;
        push_restart();
        push_char(8'h00);
        push_char(8'hFF);
        wait_idle();

        // short pattern, inactive prefixes hold pattern chars zero and all-ones
        write_pattern(3, 64'h0000_0000_0061_6261, '1);
        push_restart();
        push_char(8'h61);
        push_char(8'h62);
        push_char(8'h61);
        push_char(8'h62);
        push_char(8'h61);
        push_char(8'h00);
        wait_idle();

        // shorter pattern mid-text, no restart
        write_reg(dsc_pkg::REG_PATTERN_LENGTH, 64'd2);
        push_char(8'h62);
        wait_idle();

        // length beyond the maximum, all-ones characters
        write_pattern(31, '1, '1);
        push_restart();
        push_char(8'hFF);
        push_char(8'hFF);
        push_char(8'h00);
        wait_idle();

        // unused index must not disturb anything
        write_reg(REG_UNUSED, {$urandom, $urandom});
        write_pattern(1, '0, '0);
        push_restart();
        push_char(8'h00);
        push_char(8'h00);
        push_char(8'h80);
        wait_idle();

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            idle_level = (p >= NUM_PHASES - 2) ? 0 : $urandom_range(0, 4);
            sat_mode   = (p % 4 == 3);
            case (p)
                0: len = MAX_PAT;
                1: len = 31;
                2: len = 0;
                default: begin
                    if (sat_mode) begin
                        len = $urandom_range(8, MAX_PAT);
                    end else if ($urandom_range(0, 5) == 0) begin
                        len = $urandom_range(MAX_PAT + 1, 31);
                    end else begin
                        len = $urandom_range(1, MAX_PAT);
                    end
                end
            endcase
            eff  = (len > MAX_PAT) ? MAX_PAT : len;
            nsym = sat_mode ? 1 : $urandom_range(1, 4);
            foreach (alphabet[i]) alphabet[i] = CW'($urandom);
            for (k = 0; k < MAX_PAT; k++) begin
                if (p == 5) begin
                    pat_chars[k] = CW'($urandom);
                end else begin
                    pat_chars[k] = alphabet[$urandom_range(0, nsym - 1)];
                end
                if (k < CPW) begin
                    lo[CW*k +: CW] = pat_chars[k];
                end else begin
                    hi[CW*(k-CPW) +: CW] = pat_chars[k];
                end
            end
            if (p == 5) write_reg(REG_UNUSED, {$urandom, $urandom});
            write_pattern(len, lo, hi);

            restart_first = sat_mode || p < 3 || $urandom_range(0, 3) != 0;
            stop = beats_queued + PHASE_BEATS;
            if (restart_first) push_restart();
            while (beats_queued < stop) begin
                if (sat_mode) begin
                    run = $urandom_range(50, 100);
                    repeat (run) begin
                        if ($urandom_range(0, 9) == 0) begin
                            push_char(CW'($urandom));
                        end else begin
                            push_char(alphabet[0]);
                        end
                    end
                    push_restart();
                end else begin
                    r = $urandom_range(0, 19);
                    if (r == 0) begin
                        push_char(CW'($urandom));
                    end else if (r == 1) begin
                        push_restart();
                    end else begin
                        push_restart();
                        run = $urandom_range(3, 40);
                        repeat (run) begin
                            if (eff == 0 || $urandom_range(0, 6) == 0) begin
                                push_char(CW'($urandom));
                            end else begin
                                push_char(pat_chars[$urandom_range(0, eff - 1)]);
                            end
                        end
                    end
                end
            end
            // receiver backs off while the sender keeps offering
            if (p == 1) hold_request = 1'b1;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("%0d beats sent, %0d results checked over %0d register writes",
                 beats_queued, results_checked, cfg_writes);
        $display("%0d results carried the saturation flag, %0d mismatches",
                 saturated_seen, errors);
        if (errors == 0) begin
            $display("PASS distinct_subsequence_counter");
        end else begin
            $display("FAIL distinct_subsequence_counter");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timed out with %0d results outstanding", expected_totals.size());
        $display("FAIL distinct_subsequence_counter");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dsc_pkg.sv
rtl/dsc_cell.sv
rtl/distinct_subsequence_counter.sv
tb/tb_distinct_subsequence_counter.sv
